### rtl/core/bfhs_pkg.sv
// package: types, sizes and hash helpers for the bloom-fronted hash set
`timescale 1ns / 1ps
package bfhs_pkg;

  localparam int TableSlots   = 1024;
  localparam int FilterWords  = 512;
  localparam int SlotAw       = $clog2(TableSlots);
  localparam int FiltAw       = $clog2(FilterWords);
  localparam int FillW        = SlotAw + 1;
  // largest fill_count for which a new key is still taken: (fc+1)*10 < slots*7
  localparam int FillMaxOk    = (TableSlots * 7 + 9) / 10 - 2;
  localparam int ClrCycles    = (TableSlots > FilterWords) ? TableSlots : FilterWords;
  localparam int ClrW         = $clog2(ClrCycles);
  localparam int QDepth       = 2;

  localparam logic [63:0] MulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MulB = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    ST_ABSENT   = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       filter_pass;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        func;
    logic        zero;
    logic [63:0] key;
    logic [63:0] z;
  } job_t;

  // 64 x 64 product split into 32-bit partial products, low 64 bits
  function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    begin
      ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh = a[31:0] * b[63:32];
      hl = a[63:32] * b[31:0];
      mul_lo = ll + {lh + hl, 32'd0};
    end
  endfunction

endpackage

### rtl/core/bfhs_front.sv
// front: hash finalizer pipeline, classifies items and queues them for the back
`timescale 1ns / 1ps
module bfhs_front
  import bfhs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     q_valid,
  output job_t     q_job,
  input  logic     q_pop,
  output logic     empty
);

  // stage 0: xor-shift 30, stage 1: mul A, stage 2: xor-shift 27, mul B, stage 3: xor-shift 31
  logic        v0_r, v1_r, v2_r;
  logic        f0_r, f1_r, f2_r;
  logic [63:0] k0_r, k1_r, k2_r;
  logic [63:0] h0_r, h1_r, h2_r;
  logic [63:0] h1_nxt, h2_nxt;

  job_t             mem_r [QDepth];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  job_t             job_nxt;

  assign h1_nxt = mul_lo(h0_r, MulA);
  assign h2_nxt = mul_lo(h1_r ^ (h1_r >> 27), MulB);

  always_comb begin
    job_nxt.func = f2_r;
    job_nxt.key  = k2_r;
    job_nxt.zero = (k2_r == 64'd0);
    job_nxt.z    = h2_r ^ (h2_r >> 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      v0_r <= acc; v1_r <= v0_r; v2_r <= v1_r;
      if (v2_r) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, v2_r} - {1'b0, q_pop};
    end
    f0_r <= item.func; k0_r <= item.key; h0_r <= item.key ^ (item.key >> 30);
    f1_r <= f0_r; k1_r <= k0_r; h1_r <= h1_nxt;
    f2_r <= f1_r; k2_r <= k1_r; h2_r <= h2_nxt;
    if (v2_r) mem_r[wp_r] <= job_nxt;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rp_r];
  assign empty   = !(v0_r || v1_r || v2_r || q_valid);

endmodule

### rtl/core/bfhs_back.sv
// back: filter check, linear probe walk, insert, and reset clearing sweep
`timescale 1ns / 1ps
module bfhs_back
  import bfhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      idle,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_FREAD, S_FCHK, S_PREAD, S_PCHK} state_t;

  state_t           state_r;
  logic [ClrW-1:0]  clr_r;
  job_t             job_r;
  logic [SlotAw-1:0] idx_r;
  logic [FillW-1:0] fill_r;
  logic             pass_r;
  logic [63:0]      pat_r;
  logic [63:0]      fword_r;
  logic [63:0]      sword_r;
  logic             ov_r;
  out_item_t        oi_r;

  logic [63:0] slot_mem [TableSlots];
  logic [63:0] filt_mem [FilterWords];

  logic [FiltAw-1:0] widx;
  logic [63:0]       pat;
  logic              pass;
  assign widx = job_r.z[FiltAw-1:0];
  assign pat  = (64'd1 << job_r.z[37:32]) | (64'd1 << job_r.z[45:40]) |
                (64'd1 << job_r.z[53:48]) | (64'd1 << job_r.z[61:56]);
  assign pass = (fword_r & pat_r) == pat_r;

  always_ff @(posedge clk) begin
    fword_r <= filt_mem[widx];
    sword_r <= slot_mem[idx_r];
    ov_r    <= 1'b0;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          slot_mem[clr_r[SlotAw-1:0]] <= 64'd0;
          filt_mem[clr_r[FiltAw-1:0]] <= 64'd0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == ClrW'(ClrCycles - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            job_r <= q_job;
            if (q_job.zero) begin
              ov_r   <= 1'b1;
              oi_r   <= '{status: ST_ZERO, filter_pass: 1'b0};
            end else begin
              state_r <= S_FREAD;
            end
          end
        end
        S_FREAD: begin
          pat_r   <= pat;
          idx_r   <= job_r.z[SlotAw-1:0];
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          pass_r <= pass;
          if (job_r.func == FUNC_LOOKUP && !pass) begin
            ov_r    <= 1'b1;
            oi_r    <= '{status: ST_ABSENT, filter_pass: 1'b0};
            state_r <= S_IDLE;
          end else begin
            state_r <= S_PREAD;
          end
        end
        S_PREAD: state_r <= S_PCHK;
        S_PCHK: begin
          if (sword_r == job_r.key) begin
            ov_r    <= 1'b1;
            oi_r    <= '{status: ST_PRESENT, filter_pass: pass_r};
            state_r <= S_IDLE;
          end else if (sword_r == 64'd0) begin
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
            if (job_r.func == FUNC_LOOKUP) begin
              oi_r <= '{status: ST_ABSENT, filter_pass: pass_r};
            end else if (fill_r > FillW'(FillMaxOk)) begin
              oi_r <= '{status: ST_FULL, filter_pass: pass_r};
            end else begin
              oi_r <= '{status: ST_INSERTED, filter_pass: pass_r};
              slot_mem[idx_r] <= job_r.key;
              filt_mem[widx]  <= fword_r | pat_r;
              fill_r          <= fill_r + 1'b1;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PREAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign idle      = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule

### rtl/core/bloom_fronted_hash_set_core.sv
// top level: bloom-fronted exact hash set of nonzero 64-bit keys
`timescale 1ns / 1ps
// start/busy command port; each result shows for one cycle on out_valid and
// cannot be held off. after reset the block clears its 1024-slot table and
// filter, one entry a cycle, with busy high. an item then passes the front's
// hash stages and queue; the back answers a zero key from idle, a lookup
// that fails the filter after the filter check, else after a probe walk
// through the synchronous slot memory; busy stays high until the result is out.
module bloom_fronted_hash_set_core
  import bfhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic busy_r;
  logic q_valid, q_pop, f_empty, b_idle;
  job_t q_job;
  logic acc;

  assign acc  = start && !busy;
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else if (acc) busy_r <= 1'b1;
    else if (f_empty && b_idle && !out_valid) busy_r <= 1'b0;
  end

  bfhs_front u_front (
    .clk, .rst_n, .acc, .item(in_item),
    .q_valid, .q_job, .q_pop, .empty(f_empty)
  );

  bfhs_back u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop,
    .idle(b_idle), .out_valid, .out_item
  );

endmodule

### rtl/core/bfhs_checker.sv
// checker: port-level properties of the hash set core
`timescale 1ns / 1ps
module bfhs_checker
  import bfhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= ST_ZERO) else $error("bad status");

  a_zero_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_ZERO |-> !out_item.filter_pass)
    else $error("zero key with filter pass");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

endmodule

bind bloom_fronted_hash_set_core bfhs_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

### tb/tb_top.sv
// testbench: bloom-fronted hash set core against a behavioral set/filter predictor
`timescale 1ns / 1ps
module tb_top;
  import bfhs_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  bloom_fronted_hash_set_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state
  logic [63:0] set_slots [TableSlots];
  logic [63:0] filt_model [FilterWords];
  int unsigned keys_held;

  out_item_t   expected_q[$];
  int          mismatches;
  int          results_seen;
  int          n_inserted, n_full, n_present, n_pass;
  logic [63:0] keys_added[$];

  function automatic logic [63:0] mix64(input logic [63:0] k);
    logic [63:0] z;
    z = k ^ (k >> 30);
    z = z * MulA;
    z = z ^ (z >> 27);
    z = z * MulB;
    return z ^ (z >> 31);
  endfunction

  function automatic out_item_t apply_op(input logic op, input logic [63:0] key);
    out_item_t r;
    logic [63:0] z, pat;
    int unsigned w, idx, n;
    logic hit, found_empty;
    r.status = ST_ABSENT;
    r.filter_pass = 1'b0;
    if (key == 64'd0) begin
      r.status = ST_ZERO;
      return r;
    end
    z   = mix64(key);
    pat = (64'd1 << z[37:32]) | (64'd1 << z[45:40]) | (64'd1 << z[53:48]) |
          (64'd1 << z[61:56]);
    w   = 32'(z[FiltAw-1:0]);
    r.filter_pass = ((filt_model[w] & pat) == pat);
    if (op == FUNC_LOOKUP && !r.filter_pass) return r;
    idx = 32'(z[SlotAw-1:0]);
    hit = 1'b0;
    found_empty = 1'b0;
    for (n = 0; n < TableSlots; n++) begin
      if (set_slots[idx] == key) begin
        hit = 1'b1;
        break;
      end
      if (set_slots[idx] == 64'd0) begin
        found_empty = 1'b1;
        break;
      end
      idx = (idx + 1) & (TableSlots - 1);
    end
    if (hit) r.status = ST_PRESENT;
    else if (op == FUNC_LOOKUP) r.status = ST_ABSENT;
    else if ((keys_held + 1) * 10 >= TableSlots * 7 || !found_empty) r.status = ST_FULL;
    else begin
      set_slots[idx] = key;
      keys_held++;
      filt_model[w] |= pat;
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      out_item_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d pass=%0b",
                                       out_item.status, out_item.filter_pass);
      end else begin
        e = expected_q.pop_front();
        if (e.status !== out_item.status || e.filter_pass !== out_item.filter_pass) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d pass=%0b, got status=%0d pass=%0b",
                     e.status, e.filter_pass, out_item.status, out_item.filter_pass);
        end
      end
    end
  end

  // send one transaction; a typed expectation is checked against the predictor's status
  task automatic send_op(input logic op, input logic [63:0] key,
                         input bit typed, input status_t typed_st);
    out_item_t p;
    int gap;
    gap = $urandom_range(0, 16);
    repeat (gap) @(negedge clk);
    // busy only moves at the rising edge, so it is stable here
    while (busy) @(negedge clk);
    start   <= 1'b1;
    in_item <= '{func: op, key: key};
    @(posedge clk);
    p = apply_op(op, key);
    if (typed && p.status != typed_st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row key=%h: typed status %0d, predictor %0d", key, typed_st,
                 p.status);
    end
    expected_q.insert(expected_q.size(), p);
    if (p.status == ST_INSERTED) begin
      n_inserted++;
      keys_added.insert(keys_added.size(), key);
    end
    if (p.status == ST_FULL) n_full++;
    if (p.status == ST_PRESENT) n_present++;
    if (p.filter_pass) n_pass++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  typedef struct {
    logic        op;
    logic [63:0] key;
    bit          typed;
    status_t     st;
  } row_t;

  row_t rows[$];

  task automatic add_row(input logic op, input logic [63:0] key,
                         input bit typed, input status_t st);
    row_t r;
    r.op    = op;
    r.key   = key;
    r.typed = typed;
    r.st    = st;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    #50_000_000;
    $display("bloom_fronted_hash_set_core verification failed");
    $finish;
  end

  initial begin
    logic [63:0] k;
    int i, j, limit;
    mismatches = 0; results_seen = 0; keys_held = 0;
    n_inserted = 0; n_full = 0; n_present = 0; n_pass = 0;
    foreach (set_slots[a]) set_slots[a] = '0;
    foreach (filt_model[a]) filt_model[a] = '0;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    add_row(FUNC_LOOKUP, 64'd0, 1, ST_ZERO);
    add_row(FUNC_INSERT, 64'd0, 1, ST_ZERO);
    add_row(FUNC_LOOKUP, 64'd1, 1, ST_ABSENT);
    add_row(FUNC_LOOKUP, '1, 1, ST_ABSENT);
    add_row(FUNC_INSERT, 64'd1, 1, ST_INSERTED);
    add_row(FUNC_INSERT, '1, 1, ST_INSERTED);
    add_row(FUNC_LOOKUP, 64'd1, 1, ST_PRESENT);
    add_row(FUNC_LOOKUP, '1, 1, ST_PRESENT);
    add_row(FUNC_INSERT, 64'd1, 1, ST_PRESENT);
    add_row(FUNC_INSERT, 64'h8000_0000_0000_0000, 0, ST_ABSENT);
    add_row(FUNC_LOOKUP, 64'h8000_0000_0000_0000, 0, ST_ABSENT);
    add_row(FUNC_LOOKUP, 64'h7fff_ffff_ffff_ffff, 0, ST_ABSENT);
    add_row(FUNC_LOOKUP, 64'd2, 0, ST_ABSENT);
    add_row(FUNC_INSERT, 64'h5555_5555_5555_5555, 0, ST_ABSENT);
    add_row(FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 0, ST_ABSENT);
    foreach (rows[r]) send_op(rows[r].op, rows[r].key, rows[r].typed, rows[r].st);

    // random: mostly inserts with lookups of held and fresh keys
    for (i = 0; i < 40; i++) begin
      j = $urandom_range(0, 99);
      k = {$urandom(), $urandom()};
      if (j < 3) k = 64'd0;
      else if (j < 8) k = 64'd1 << $urandom_range(0, 63);
      else if (j < 30 && keys_added.size() > 0)
        k = keys_added[$urandom_range(0, keys_added.size() - 1)];
      send_op((j % 3 != 0) ? FUNC_INSERT : FUNC_LOOKUP, k, 0, ST_ABSENT);
    end
    // drive toward the fill limit, then prove refusal and present-when-full
    limit = 0;
    while (n_full < 4 && limit < 760) begin
      send_op(FUNC_INSERT, {$urandom(), $urandom()}, 0, ST_ABSENT);
      limit++;
    end
    for (i = 0; i < 12; i++) begin
      k = keys_added[$urandom_range(0, keys_added.size() - 1)];
      send_op(1'($urandom_range(0, 1)), k, 0, ST_ABSENT);
    end
    for (i = 0; i < 12; i++) send_op(FUNC_LOOKUP, {$urandom(), $urandom()}, 0, ST_ABSENT);

    limit = 0;
    while (expected_q.size() > 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d results: %0d inserts, %0d present, %0d refused full,",
             results_seen, n_inserted, n_present, n_full);
    $display("  %0d filter hits, zero keys and a table filled to its limit", n_pass);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("bloom_fronted_hash_set_core verification clean");
    else
      $display("bloom_fronted_hash_set_core verification failed");
    $finish;
  end
endmodule

### sim.f
rtl/core/bfhs_pkg.sv
rtl/core/bfhs_front.sv
rtl/core/bfhs_back.sv
rtl/core/bloom_fronted_hash_set_core.sv
rtl/core/bfhs_checker.sv
tb/tb_top.sv
